@@ rtl/cpd_pkg.sv @@
package cpd_pkg;

    localparam logic [15:0] CRC_POLY = 16'h8005;
    localparam logic [15:0] MIN_LEN  = 16'd5;
    localparam logic [15:0] HDR_LEN  = 16'd9;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_SHORT     = 2'd1;
    localparam logic [1:0] ST_BAD_CRC   = 2'd2;
    localparam logic [1:0] ST_LEN_MISM  = 2'd3;

    // results caused by one input beat: optional data byte, optional status
    typedef struct packed {
        logic        has_data;
        logic [7:0]  data_byte;
        logic [15:0] data_index;
        logic        has_status;
        logic [1:0]  status_code;
        logic [7:0]  opcode;
        logic [7:0]  param_one;
        logic [7:0]  param_two;
        logic [15:0] param_three;
        logic [15:0] payload_length;
    } rec_t;

endpackage

@@ rtl/cpd_parser.sv @@
module cpd_parser (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [7:0]    s_rx_byte,
    input  logic          s_end_of_burst,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [7:0]    cfg_start_marker,
    output logic          rec_valid,
    output cpd_pkg::rec_t rec,
    input  logic          rec_ready
);
    import cpd_pkg::*;

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        in_eob_reg;
    logic [7:0]  marker_reg;
    logic        hunting_reg, hunting_next;
    logic [15:0] count_reg, count_next;
    logic [15:0] crc_reg, crc_next;
    logic [15:0] hold_reg, hold_next;
    logic [15:0] decl_reg, decl_next;
    logic [7:0]  op_reg, op_next;
    logic [7:0]  p1_reg, p1_next;
    logic [7:0]  p2_reg, p2_next;
    logic [15:0] p3_reg, p3_next;

    logic        proc;
    logic        accept;
    logic [15:0] crc_upd, hold_upd, decl_upd, p3_upd, count_upd;
    logic [7:0]  op_upd, p1_upd, p2_upd;
    logic        emit_data, emit_status;
    rec_t        status_rec;

    function automatic logic [15:0] crc_byte(input logic [15:0] r, input logic [7:0] b);
        logic [15:0] c;
        logic        top;
        c = r;
        for (int i = 0; i < 8; i++) begin
            top = c[15] ^ b[7-i];
            c   = {c[14:0], 1'b0};
            if (top) c = c ^ CRC_POLY;
        end
        return c;
    endfunction

    function automatic rec_t make_status(input logic [15:0] n, input logic [15:0] crc,
                                         input logic [15:0] hold, input logic [15:0] decl,
                                         input logic [7:0] op, input logic [7:0] p1,
                                         input logic [7:0] p2, input logic [15:0] p3);
        rec_t r;
        r = '0;
        r.has_status = 1'b1;
        if (n < MIN_LEN)                       r.status_code = ST_SHORT;
        else if ({hold[7:0], hold[15:8]} != crc) r.status_code = ST_BAD_CRC;
        else if (decl != n)                    r.status_code = ST_LEN_MISM;
        else                                   r.status_code = ST_OK;
        r.opcode         = (n > 16'd2) ? op : 8'd0;
        r.param_one      = (n > 16'd5) ? p1 : 8'd0;
        r.param_two      = (n > 16'd6) ? p2 : 8'd0;
        r.param_three    = (n > 16'd8) ? p3 : 16'd0;
        r.payload_length = (n > HDR_LEN) ? n - HDR_LEN : 16'd0;
        return r;
    endfunction

    assign cfg_ready = 1'b1;
    assign proc      = in_valid_reg & rec_ready;
    assign s_ready   = ~in_valid_reg | proc;
    assign accept    = s_valid & s_ready;

    always_comb begin
        crc_upd   = (count_reg >= 16'd2) ? crc_byte(crc_reg, hold_reg[15:8]) : crc_reg;
        hold_upd  = {hold_reg[7:0], in_byte_reg};
        decl_upd  = decl_reg;
        op_upd    = op_reg;
        p1_upd    = p1_reg;
        p2_upd    = p2_reg;
        p3_upd    = p3_reg;
        case (count_reg)
            16'd0:   decl_upd = {decl_reg[15:8], in_byte_reg};
            16'd1:   decl_upd = {in_byte_reg, decl_reg[7:0]};
            16'd2:   op_upd   = in_byte_reg;
            16'd3:   p1_upd   = in_byte_reg;
            16'd4:   p2_upd   = in_byte_reg;
            16'd5:   p3_upd   = {p3_reg[15:8], in_byte_reg};
            16'd6:   p3_upd   = {in_byte_reg, p3_reg[7:0]};
            default: ;
        endcase
        count_upd = (count_reg != 16'hFFFF) ? count_reg + 16'd1 : count_reg;
    end

    always_comb begin
        emit_data   = 1'b0;
        emit_status = 1'b0;
        status_rec  = make_status(16'd0, 16'd0, 16'd0, 16'd0, 8'd0, 8'd0, 8'd0, 16'd0);
        if (hunting_reg) begin
            emit_status = (in_byte_reg == marker_reg) & in_eob_reg;
        end else begin
            emit_data   = (count_reg >= 16'd7) &&
                          ({1'b0, count_reg} + 17'd2 < {1'b0, decl_reg});
            emit_status = in_eob_reg;
            status_rec  = make_status(count_upd, crc_upd, hold_upd, decl_upd,
                                      op_upd, p1_upd, p2_upd, p3_upd);
        end
        rec            = status_rec;
        rec.has_status = emit_status;
        rec.has_data   = emit_data;
        rec.data_byte  = in_byte_reg;
        rec.data_index = count_reg - 16'd7;
    end

    assign rec_valid = in_valid_reg & (emit_data | emit_status);

    always_comb begin
        in_valid_next = in_valid_reg;
        hunting_next  = hunting_reg;
        count_next    = count_reg;
        crc_next      = crc_reg;
        hold_next     = hold_reg;
        decl_next     = decl_reg;
        op_next       = op_reg;
        p1_next       = p1_reg;
        p2_next       = p2_reg;
        p3_next       = p3_reg;
        if (proc) begin
            in_valid_next = 1'b0;
            if (hunting_reg) begin
                if (in_byte_reg == marker_reg) begin
                    hunting_next = in_eob_reg;
                    count_next   = '0;
                    crc_next     = '0;
                    hold_next    = '0;
                    decl_next    = '0;
                    op_next      = '0;
                    p1_next      = '0;
                    p2_next      = '0;
                    p3_next      = '0;
                end
            end else if (in_eob_reg) begin
                hunting_next = 1'b1;
                count_next   = '0;
                crc_next     = '0;
                hold_next    = '0;
                decl_next    = '0;
                op_next      = '0;
                p1_next      = '0;
                p2_next      = '0;
                p3_next      = '0;
            end else begin
                count_next = count_upd;
                crc_next   = crc_upd;
                hold_next  = hold_upd;
                decl_next  = decl_upd;
                op_next    = op_upd;
                p1_next    = p1_upd;
                p2_next    = p2_upd;
                p3_next    = p3_upd;
            end
        end
        if (accept) in_valid_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            marker_reg   <= '0;
            hunting_reg  <= 1'b1;
            count_reg    <= '0;
            crc_reg      <= '0;
            hold_reg     <= '0;
            decl_reg     <= '0;
            op_reg       <= '0;
            p1_reg       <= '0;
            p2_reg       <= '0;
            p3_reg       <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            if (cfg_valid && cfg_ready) marker_reg <= cfg_start_marker;
            hunting_reg  <= hunting_next;
            count_reg    <= count_next;
            crc_reg      <= crc_next;
            hold_reg     <= hold_next;
            decl_reg     <= decl_next;
            op_reg       <= op_next;
            p1_reg       <= p1_next;
            p2_reg       <= p2_next;
            p3_reg       <= p3_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            in_byte_reg <= s_rx_byte;
            in_eob_reg  <= s_end_of_burst;
        end
    end

endmodule

@@ rtl/cpd_outq.sv @@
module cpd_outq (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          rec_valid,
    output logic          rec_ready,
    input  cpd_pkg::rec_t rec,
    output logic          m_valid,
    input  logic          m_ready,
    output logic          m_is_status,
    output logic [7:0]    m_data_byte,
    output logic [15:0]   m_data_index,
    output logic [1:0]    m_status_code,
    output logic [7:0]    m_opcode,
    output logic [7:0]    m_param_one,
    output logic [7:0]    m_param_two,
    output logic [15:0]   m_param_three,
    output logic [15:0]   m_payload_length,
    output logic          m_last
);
    import cpd_pkg::*;

    localparam int unsigned DEPTH = 2;

    rec_t       q_reg [DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       phase_reg, phase_next;
    rec_t       head;
    logic       push, pop, beat;

    assign head      = q_reg[rd_ptr_reg];
    assign rec_ready = (cnt_reg != 2'(DEPTH));
    assign push      = rec_valid & rec_ready;
    assign m_valid   = (cnt_reg != 2'd0);

    assign m_is_status = ~head.has_data | phase_reg;
    assign m_last      = m_is_status | ~head.has_status;
    assign beat        = m_valid & m_ready;
    assign pop         = beat & m_last;

    assign m_data_byte      = m_is_status ? 8'd0 : head.data_byte;
    assign m_data_index     = m_is_status ? 16'd0 : head.data_index;
    assign m_status_code    = m_is_status ? head.status_code : ST_OK;
    assign m_opcode         = m_is_status ? head.opcode : 8'd0;
    assign m_param_one      = m_is_status ? head.param_one : 8'd0;
    assign m_param_two      = m_is_status ? head.param_two : 8'd0;
    assign m_param_three    = m_is_status ? head.param_three : 16'd0;
    assign m_payload_length = m_is_status ? head.payload_length : 16'd0;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
        phase_next  = beat ? ~m_last : phase_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
            phase_reg  <= 1'b0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
            phase_reg  <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) q_reg[wr_ptr_reg] <= rec;
    end

endmodule

@@ rtl/crc_checked_packet_deframer.sv @@
// Results of an s_ beat pass the parser input register and then the output queue to m_.
// Throughput: one input beat per cycle while the output queue has room; a beat causing
// a data byte and a status needs two output beats; the output port then sets the rate.
// Reset (aresetn low, synchronous): start marker 0, parser hunting, output queue empty.
module crc_checked_packet_deframer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    input  logic        s_end_of_burst,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_start_marker,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_is_status,
    output logic [7:0]  m_data_byte,
    output logic [15:0] m_data_index,
    output logic [1:0]  m_status_code,
    output logic [7:0]  m_opcode,
    output logic [7:0]  m_param_one,
    output logic [7:0]  m_param_two,
    output logic [15:0] m_param_three,
    output logic [15:0] m_payload_length,
    output logic        m_last
);
    import cpd_pkg::*;

    logic rec_valid, rec_ready;
    rec_t rec;

    cpd_parser u_parser (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rx_byte        (s_rx_byte),
        .s_end_of_burst   (s_end_of_burst),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_start_marker (cfg_start_marker),
        .rec_valid        (rec_valid),
        .rec              (rec),
        .rec_ready        (rec_ready)
    );

    cpd_outq u_outq (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .rec_valid        (rec_valid),
        .rec_ready        (rec_ready),
        .rec              (rec),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_is_status      (m_is_status),
        .m_data_byte      (m_data_byte),
        .m_data_index     (m_data_index),
        .m_status_code    (m_status_code),
        .m_opcode         (m_opcode),
        .m_param_one      (m_param_one),
        .m_param_two      (m_param_two),
        .m_param_three    (m_param_three),
        .m_payload_length (m_payload_length),
        .m_last           (m_last)
    );

endmodule

@@ rtl/cpd_checker.sv @@
module cpd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_is_status,
    input logic [7:0]  m_data_byte,
    input logic [15:0] m_data_index,
    input logic [1:0]  m_status_code,
    input logic [7:0]  m_opcode,
    input logic [15:0] m_payload_length,
    input logic        m_last
);
    import cpd_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_is_status) && $stable(m_data_byte)
            && $stable(m_data_index) && $stable(m_last))
        else $error("result beat changed while stalled");

    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_status |-> m_last)
        else $error("status beat not marked last");

    a_data_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_is_status |-> m_status_code == ST_OK && m_opcode == 8'd0
            && m_payload_length == 16'd0)
        else $error("data beat carries header fields");

    a_status_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_status |-> m_data_byte == 8'd0 && m_data_index == 16'd0)
        else $error("status beat carries data fields");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result offered straight after reset");

endmodule

bind crc_checked_packet_deframer cpd_checker u_cpd_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_is_status      (m_is_status),
    .m_data_byte      (m_data_byte),
    .m_data_index     (m_data_index),
    .m_status_code    (m_status_code),
    .m_opcode         (m_opcode),
    .m_payload_length (m_payload_length),
    .m_last           (m_last)
);
